// ===== rtl/core/fmacl_pkg.sv =====
package fmacl_pkg;

    localparam int MAX_RULES_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int PROTO_W  = 8;
    localparam int PORT_W   = 16;
    localparam int FLAGS_W  = 2;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    typedef struct packed {
        logic                load;
        logic                advance;
        logic                append;
        logic                shift;
        logic                dec;
        logic                clear;
        logic                finish;
        logic                hit;
        logic [STATUS_W-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              full;
        logic              idx_bad;
        logic              idx_last;
        logic              hit;
        logic              last;
    } t_stat;

endpackage

// ===== rtl/core/fmacl_ctrl.sv =====
module fmacl_ctrl
    import fmacl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_LK_RD  = 3'd2;
    localparam logic [2:0] ST_LK_CMP = 3'd3;
    localparam logic [2:0] ST_DL_RD  = 3'd4;
    localparam logic [2:0] ST_DL_WR  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_stat.func)
                    FUNC_LOOKUP: begin
                        if (i_stat.empty) begin
                            cmd.finish = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_state = ST_LK_RD;
                        end
                    end
                    FUNC_ADD: begin
                        cmd.finish = 1'b1;
                        n_state    = ST_IDLE;
                        if (i_stat.full) begin
                            cmd.status = STATUS_FULL;
                        end else begin
                            cmd.append = 1'b1;
                        end
                    end
                    FUNC_DEL: begin
                        if (i_stat.idx_bad) begin
                            cmd.finish = 1'b1;
                            cmd.status = STATUS_RANGE;
                            n_state    = ST_IDLE;
                        end else if (i_stat.idx_last) begin
                            cmd.dec    = 1'b1;
                            cmd.finish = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            n_state = ST_DL_RD;
                        end
                    end
                    FUNC_CLEAR: begin
                        cmd.clear  = 1'b1;
                        cmd.finish = 1'b1;
                        n_state    = ST_IDLE;
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = ST_IDLE;
                    end
                endcase
            end
            ST_LK_RD: begin
                cmd.advance = 1'b1;
                n_state     = ST_LK_CMP;
            end
            ST_LK_CMP: begin
                if (i_stat.hit) begin
                    cmd.finish = 1'b1;
                    cmd.hit    = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_stat.last) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_DL_RD: begin
                cmd.advance = 1'b1;
                n_state     = ST_DL_WR;
            end
            ST_DL_WR: begin
                cmd.shift = 1'b1;
                if (i_stat.last) begin
                    cmd.dec    = 1'b1;
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/fmacl_dp.sv =====
module fmacl_dp
    import fmacl_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ADDR_W-1:0]   i_src_ip,
    input  logic [ADDR_W-1:0]   i_src_ipmask,
    input  logic [ADDR_W-1:0]   i_dst_ip,
    input  logic [ADDR_W-1:0]   i_dst_ipmask,
    input  logic [PROTO_W-1:0]  i_proto,
    input  logic [PORT_W-1:0]   i_src_port_low,
    input  logic [PORT_W-1:0]   i_src_port_high,
    input  logic [PORT_W-1:0]   i_dst_port_low,
    input  logic [PORT_W-1:0]   i_dst_port_high,
    input  logic [FLAGS_W-1:0]  i_flags,
    input  logic [IDX_W-1:0]    i_index,
    output logic                o_done,
    output logic                o_allow,
    output logic                o_matched,
    output logic [IDX_W-1:0]    o_match_index,
    output logic [STATUS_W-1:0] o_status,
    output logic [HELD_W-1:0]   o_rules_held
);

    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int XW = CW + IDX_W;
    localparam int HW = CW + HELD_W;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_ip;
        logic [ADDR_W-1:0]  src_ipmask;
        logic [ADDR_W-1:0]  dst_ip;
        logic [ADDR_W-1:0]  dst_ipmask;
        logic [PORT_W-1:0]  sp_lo;
        logic [PORT_W-1:0]  sp_hi;
        logic [PORT_W-1:0]  dp_lo;
        logic [PORT_W-1:0]  dp_hi;
        logic               port_check;
        logic               allow;
        logic [PROTO_W-1:0] proto;
    } t_rule;

    t_rule              r_mem [MAX_RULES];
    t_rule              r_rd_data;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_eval_idx;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    logic [FUNC_W-1:0]  r_func;
    logic [ADDR_W-1:0]  r_sa;
    logic [ADDR_W-1:0]  r_sm;
    logic [ADDR_W-1:0]  r_da;
    logic [ADDR_W-1:0]  r_dm;
    logic [PROTO_W-1:0] r_proto;
    logic [PORT_W-1:0]  r_spl;
    logic [PORT_W-1:0]  r_sph;
    logic [PORT_W-1:0]  r_dpl;
    logic [PORT_W-1:0]  r_dph;
    logic [FLAGS_W-1:0] r_flags;
    logic [IDX_W-1:0]   r_idx;

    logic                r_done;
    logic                r_allow;
    logic                r_matched;
    logic [IDX_W-1:0]    r_mindex;
    logic [STATUS_W-1:0] r_status;
    logic [HELD_W-1:0]   r_held;

    t_rule              new_rule;
    t_rule              wr_data;
    logic [IW-1:0]      wr_addr;
    logic               wr_en;
    logic [CW-1:0]      eval_dec;
    logic [XW-1:0]      idx_ext;
    logic [XW-1:0]      cnt_ext;
    logic [XW-1:0]      idx_inc;
    logic [XW-1:0]      ld_idx_inc;
    logic [HW-1:0]      held_ext;
    logic [XW-1:0]      eval_ext;
    logic               l4_ports;
    logic [PORT_W-1:0]  pkt_sp;
    logic [PORT_W-1:0]  pkt_dp;
    logic               src_ok;
    logic               dst_ok;
    logic               port_ok;
    logic               hit;

    always_comb begin
        new_rule.src_ip      = r_sa;
        new_rule.src_ipmask  = r_sm;
        new_rule.dst_ip      = r_da;
        new_rule.dst_ipmask  = r_dm;
        new_rule.sp_lo       = r_spl;
        new_rule.sp_hi       = r_sph;
        new_rule.dp_lo       = r_dpl;
        new_rule.dp_hi       = r_dph;
        new_rule.port_check  = r_flags[1];
        new_rule.allow       = r_flags[0];
        new_rule.proto       = r_proto;
    end

    assign eval_dec   = r_eval_idx - CW'(1);
    assign idx_ext    = {{CW{1'b0}}, r_idx};
    assign cnt_ext    = {{IDX_W{1'b0}}, r_count};
    assign idx_inc    = idx_ext + XW'(1);
    assign ld_idx_inc = {{CW{1'b0}}, i_index} + XW'(1);

    always_comb begin
        wr_en   = i_cmd.append | i_cmd.shift;
        wr_data = i_cmd.append ? new_rule : r_rd_data;
        wr_addr = i_cmd.append ? r_count[IW-1:0] : eval_dec[IW-1:0];
    end

    assign l4_ports = r_flags[0] && ((r_proto == PROTO_TCP) || (r_proto == PROTO_UDP));
    assign pkt_sp   = l4_ports ? r_spl : '0;
    assign pkt_dp   = l4_ports ? r_dpl : '0;

    always_comb begin
        src_ok  = (r_rd_data.src_ipmask == '0) ||
                  ((r_sa & r_rd_data.src_ipmask) ==
                   (r_rd_data.src_ip & r_rd_data.src_ipmask));
        dst_ok  = (r_rd_data.dst_ipmask == '0) ||
                  ((r_da & r_rd_data.dst_ipmask) ==
                   (r_rd_data.dst_ip & r_rd_data.dst_ipmask));
        port_ok = !r_rd_data.port_check ||
                  (((r_rd_data.proto == '0) || (r_rd_data.proto == r_proto)) &&
                   (pkt_sp >= r_rd_data.sp_lo) && (pkt_sp <= r_rd_data.sp_hi) &&
                   (pkt_dp >= r_rd_data.dp_lo) && (pkt_dp <= r_rd_data.dp_hi));
        hit     = src_ok && dst_ok && port_ok;
    end

    always_comb begin
        o_stat.func     = r_func;
        o_stat.empty    = (r_count == '0);
        o_stat.full     = (r_count >= CW'(MAX_RULES));
        o_stat.idx_bad  = (idx_ext >= cnt_ext);
        o_stat.idx_last = (idx_inc == cnt_ext);
        o_stat.hit      = hit;
        o_stat.last     = (r_eval_idx == (r_count - CW'(1)));
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.dec) begin
            n_count = r_count - CW'(1);
        end
    end

    assign held_ext = {{HELD_W{1'b0}}, n_count};
    assign eval_ext = {{IDX_W{1'b0}}, r_eval_idx};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.advance) begin
            r_rd_data <= r_mem[r_ptr[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_sa    <= i_src_ip;
            r_sm    <= i_src_ipmask;
            r_da    <= i_dst_ip;
            r_dm    <= i_dst_ipmask;
            r_proto <= i_proto;
            r_spl   <= i_src_port_low;
            r_sph   <= i_src_port_high;
            r_dpl   <= i_dst_port_low;
            r_dph   <= i_dst_port_high;
            r_flags <= i_flags;
            r_idx   <= i_index;
            if (i_func == FUNC_DEL) begin
                r_ptr <= ld_idx_inc[CW-1:0];
            end else begin
                r_ptr <= '0;
            end
        end else if (i_cmd.advance) begin
            r_ptr      <= r_ptr + CW'(1);
            r_eval_idx <= r_ptr;
        end
        if (i_cmd.finish) begin
            r_allow   <= i_cmd.hit ? r_rd_data.allow : (r_func == FUNC_LOOKUP);
            r_matched <= i_cmd.hit;
            r_mindex  <= i_cmd.hit ? eval_ext[IDX_W-1:0] : '0;
            r_status  <= i_cmd.status;
            r_held    <= held_ext[HELD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
        end
    end

    assign o_done        = r_done;
    assign o_allow       = r_allow;
    assign o_matched     = r_matched;
    assign o_match_index = r_mindex;
    assign o_status      = r_status;
    assign o_rules_held  = r_held;

endmodule

// ===== rtl/core/first_match_packet_acl.sv =====
// Lookup compares the held rules in order from index 0 and stops at the first match or after
// the last held rule; an empty table answers without reading a rule.
// Delete at index k below n - 1 of n rules shifts every later rule down by one; deleting the last
// rule, add, clear and errors read no rule. Throughput: one transaction at a time, one rule read
// per cycle. busy drops with the result strobe, so the next transaction is taken then.
// Reset (synchronous, active low) empties the rule table and aborts any transaction.
module first_match_packet_acl
    import fmacl_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [ADDR_W-1:0]   i_src_ip,
    input  logic [ADDR_W-1:0]   i_src_ipmask,
    input  logic [ADDR_W-1:0]   i_dst_ip,
    input  logic [ADDR_W-1:0]   i_dst_ipmask,
    input  logic [PROTO_W-1:0]  i_proto,
    input  logic [PORT_W-1:0]   i_src_port_low,
    input  logic [PORT_W-1:0]   i_src_port_high,
    input  logic [PORT_W-1:0]   i_dst_port_low,
    input  logic [PORT_W-1:0]   i_dst_port_high,
    input  logic [FLAGS_W-1:0]  i_flags,
    input  logic [IDX_W-1:0]    i_index,
    output logic                o_done,
    output logic                o_allow,
    output logic                o_matched,
    output logic [IDX_W-1:0]    o_match_index,
    output logic [STATUS_W-1:0] o_status,
    output logic [HELD_W-1:0]   o_rules_held
);

    t_cmd  cmd;
    t_stat stat;

    fmacl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    fmacl_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_func          (i_func),
        .i_src_ip        (i_src_ip),
        .i_src_ipmask    (i_src_ipmask),
        .i_dst_ip        (i_dst_ip),
        .i_dst_ipmask    (i_dst_ipmask),
        .i_proto         (i_proto),
        .i_src_port_low  (i_src_port_low),
        .i_src_port_high (i_src_port_high),
        .i_dst_port_low  (i_dst_port_low),
        .i_dst_port_high (i_dst_port_high),
        .i_flags         (i_flags),
        .i_index         (i_index),
        .o_done          (o_done),
        .o_allow         (o_allow),
        .o_matched       (o_matched),
        .o_match_index   (o_match_index),
        .o_status        (o_status),
        .o_rules_held    (o_rules_held)
    );

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted transaction did not raise busy");

    a_full_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != STATUS_OK)) |-> (!o_matched && !o_allow))
        else $error("error status with lookup verdict");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.append, cmd.dec, cmd.clear}))
        else $error("conflicting rule count updates");

endmodule
